@@ rtl/voxel_surface_extract_6n_core_macros.svh @@
// Assertion macros for the voxel surface extractor.
// Used by the top level; expects clk and rst_n in scope.
`ifndef VOXEL_SURFACE_EXTRACT_6N_CORE_MACROS_SVH
`define VOXEL_SURFACE_EXTRACT_6N_CORE_MACROS_SVH

`define VSE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define VSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vse_pkg.sv @@
// Shared constants and types for the voxel surface extractor.
// No dependencies; used by the interfaces, the window RAM and the top level.
package vse_pkg;

    localparam int MAX_SIDE_DEFAULT = 64;
    localparam int MIN_SIDE         = 2;
    localparam int RESET_SIDE       = 64;

    localparam int CFG_W   = 7;
    localparam int POS_W   = 6;
    localparam int TOTAL_W = 19;

    // window entry: bit of the previous plane and of the plane before it
    localparam int ENTRY_W   = 2;
    localparam int BIT_OLDER = 0;
    localparam int BIT_RECENT = 1;

    typedef struct packed {
        logic xlo;
        logic xhi;
        logic ylo;
        logic yhi;
        logic zlo;
        logic zhi;
    } vse_edge_t;

endpackage

@@ rtl/vse_if.sv @@
// Item channels of the voxel surface extractor: voxel input and result output.
// Depends on vse_pkg for field widths.
interface vse_in_if;
    logic valid;
    logic ready;
    logic occupied;
    logic pad;

    modport source (output valid, output occupied, output pad, input ready);
    modport sink (input valid, input occupied, input pad, output ready);
endinterface

interface vse_out_if;
    logic                          valid;
    logic                          ready;
    logic                          surface;
    logic [vse_pkg::POS_W-1:0]     pos_x;
    logic [vse_pkg::POS_W-1:0]     pos_y;
    logic [vse_pkg::POS_W-1:0]     pos_z;
    logic [vse_pkg::TOTAL_W-1:0]   surface_total;
    logic                          final_voxel;

    modport source (
        output valid, output surface, output pos_x, output pos_y, output pos_z,
        output surface_total, output final_voxel, input ready
    );
    modport sink (
        input valid, input surface, input pos_x, input pos_y, input pos_z,
        input surface_total, input final_voxel, output ready
    );
endinterface

@@ rtl/voxel_surface_extract_6n_core.sv @@
// Channel   Dir  Fields                                             Handshake
// voxels    in   occupied, pad                                      valid/ready
// results   out  surface, pos_x/y/z, surface_total, final_voxel     valid/ready
// cfg       in   cfg_data (grid_side)                               cfg_we
//
// One voxel item per cycle while results are taken; a result passes stage 1 and the
// result register with the item that completes its neighbourhood. The window RAM is
// read once per item at two addresses and written back as that item leaves stage 1,
// which sets the one-item-per-cycle rate. Reset clears counters and handshake state
// and sets the grid side; the RAM needs no clearing pass. A full result register
// with a pending result stalls the input stage, and with it the voxel channel.
// Depends on vse_pkg, vse_if, vse_window_ram, vse_line_delay and the macros header.
`include "voxel_surface_extract_6n_core_macros.svh"

module voxel_surface_extract_6n_core #(
    parameter int MAX_SIDE = vse_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [vse_pkg::CFG_W-1:0]  cfg_data,
    vse_in_if.sink                     voxels,
    vse_out_if.source                  results
);

    localparam int SW       = $clog2(MAX_SIDE);
    localparam int GW       = $clog2(MAX_SIDE + 1);
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int AW       = $clog2(DEPTH);
    localparam int PW       = $clog2(DEPTH + 1);
    localparam int SUMW     = PW + 1;
    localparam int RST_SIDE = (vse_pkg::RESET_SIDE > MAX_SIDE) ? MAX_SIDE : vse_pkg::RESET_SIDE;
    localparam int TOTAL_W  = vse_pkg::TOTAL_W;
    localparam int POS_W    = vse_pkg::POS_W;

    logic [GW-1:0]      side_reg;
    logic [PW-1:0]      plane_reg;
    logic [SW-1:0]      x_in_reg;
    logic [SW-1:0]      y_in_reg;
    logic [GW-1:0]      z_in_reg;
    logic [AW-1:0]      addr_reg;
    logic [SW-1:0]      x_in_next;
    logic [SW-1:0]      y_in_next;
    logic [GW-1:0]      z_in_next;
    logic [AW-1:0]      addr_next;

    logic [GW-1:0]      side_clamped;
    logic [2*GW-1:0]    side_sq;
    logic [GW-1:0]      side_m1;
    logic               x_last;
    logic               y_last;
    logic               in_voxel;
    logic               in_produce;
    logic               in_final;
    vse_pkg::vse_edge_t in_edge;
    logic [SUMW-1:0]    ahead_sum;
    logic [AW-1:0]      ahead_addr;
    logic               in_acc;
    logic               in_take;

    logic               s1_valid_reg;
    logic               s1_produce_reg;
    logic               s1_final_reg;
    logic               s1_cur_reg;
    vse_pkg::vse_edge_t s1_edge_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [SW-1:0]      s1_x_reg;
    logic [SW-1:0]      s1_y_reg;
    logic [GW-1:0]      s1_z_reg;
    logic               s1_adv;

    logic [vse_pkg::ENTRY_W-1:0] win_data;
    logic               v_center;
    logic               v_older;
    logic               v_ahead_row;
    logic               v_ahead_one;
    logic               v_back_row;
    logic               prev_center_reg;
    logic               empty_face;
    logic               surf;

    logic [TOTAL_W-1:0] count_reg;
    logic [TOTAL_W-1:0] count_next;

    logic               out_valid_reg;
    logic               out_surface_reg;
    logic [POS_W-1:0]   out_x_reg;
    logic [POS_W-1:0]   out_y_reg;
    logic [POS_W-1:0]   out_z_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_final_reg;

    // configuration
    always_comb
    begin
        if (int'(cfg_data) < vse_pkg::MIN_SIDE)
        begin
            side_clamped = GW'(vse_pkg::MIN_SIDE);
        end
        else if (int'(cfg_data) > MAX_SIDE)
        begin
            side_clamped = GW'(MAX_SIDE);
        end
        else
        begin
            side_clamped = GW'(cfg_data);
        end
        side_sq = {GW'(0), side_clamped} * {GW'(0), side_clamped};
    end

    // input stage
    always_comb
    begin
        side_m1    = side_reg - GW'(1);
        x_last     = (GW'(x_in_reg) == side_m1);
        y_last     = (GW'(y_in_reg) == side_m1);
        in_voxel   = (z_in_reg != side_reg);
        in_produce = (z_in_reg != '0);
        in_final   = (z_in_reg == side_reg) && x_last && y_last;

        in_edge.xlo = (x_in_reg == '0);
        in_edge.xhi = x_last;
        in_edge.ylo = (y_in_reg == '0);
        in_edge.yhi = y_last;
        in_edge.zlo = (z_in_reg == GW'(1));
        in_edge.zhi = (z_in_reg == side_reg);

        ahead_sum = SUMW'(addr_reg) + SUMW'(side_reg);
        if (ahead_sum >= SUMW'(plane_reg))
        begin
            ahead_addr = AW'(ahead_sum - SUMW'(plane_reg));
        end
        else
        begin
            ahead_addr = AW'(ahead_sum);
        end
    end

    always_comb
    begin
        x_in_next = x_in_reg + SW'(1);
        y_in_next = y_in_reg;
        z_in_next = z_in_reg;
        addr_next = addr_reg + AW'(1);
        if (in_final)
        begin
            x_in_next = '0;
            y_in_next = '0;
            z_in_next = '0;
            addr_next = '0;
        end
        else if (x_last)
        begin
            x_in_next = '0;
            if (y_last)
            begin
                y_in_next = '0;
                z_in_next = z_in_reg + GW'(1);
                addr_next = '0;
            end
            else
            begin
                y_in_next = y_in_reg + SW'(1);
            end
        end
    end

    assign s1_adv        = s1_valid_reg && (!s1_produce_reg || !out_valid_reg || results.ready);
    assign voxels.ready  = !s1_valid_reg || s1_adv;
    assign in_acc        = voxels.valid && voxels.ready;
    // drop early pad items
    assign in_take       = in_acc && !(in_voxel && voxels.pad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= GW'(RST_SIDE);
            plane_reg <= PW'(RST_SIDE * RST_SIDE);
            x_in_reg  <= '0;
            y_in_reg  <= '0;
            z_in_reg  <= '0;
            addr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            side_reg  <= side_clamped;
            plane_reg <= PW'(side_sq);
            x_in_reg  <= '0;
            y_in_reg  <= '0;
            z_in_reg  <= '0;
            addr_reg  <= '0;
        end
        else if (in_take)
        begin
            x_in_reg  <= x_in_next;
            y_in_reg  <= y_in_next;
            z_in_reg  <= z_in_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_produce_reg <= in_produce;
            s1_final_reg   <= in_final;
            s1_cur_reg     <= in_voxel && voxels.occupied;
            s1_edge_reg    <= in_edge;
            s1_addr_reg    <= addr_reg;
            s1_x_reg       <= x_in_reg;
            s1_y_reg       <= y_in_reg;
            s1_z_reg       <= z_in_reg - GW'(1);
        end
    end

    // window RAM: entries of one plane apart never meet within two items
    vse_window_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_window (
        .clk         (clk),
        .rd_en       (in_take),
        .rd_addr_a   (addr_reg),
        .rd_addr_b   (ahead_addr),
        .rd_data_a   (win_data),
        .rd_recent_b (v_ahead_row),
        .wr_en       (s1_adv),
        .wr_addr     (s1_addr_reg),
        .wr_data     ({s1_cur_reg, v_center})
    );

    assign v_center = win_data[vse_pkg::BIT_RECENT];
    assign v_older  = win_data[vse_pkg::BIT_OLDER];

    vse_line_delay #(
        .DEPTH (MAX_SIDE),
        .TW    (SW)
    ) u_delay_ahead (
        .clk      (clk),
        .shift_en (s1_adv),
        .tap      (SW'(side_reg - GW'(2))),
        .din      (v_ahead_row),
        .dout     (v_ahead_one)
    );

    vse_line_delay #(
        .DEPTH (MAX_SIDE),
        .TW    (SW)
    ) u_delay_back (
        .clk      (clk),
        .shift_en (s1_adv),
        .tap      (SW'(side_m1)),
        .din      (v_center),
        .dout     (v_back_row)
    );

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            prev_center_reg <= v_center;
        end
    end

    // face test
    always_comb
    begin
        empty_face = s1_edge_reg.xlo || !prev_center_reg
                  || s1_edge_reg.xhi || !v_ahead_one
                  || s1_edge_reg.ylo || !v_back_row
                  || s1_edge_reg.yhi || !v_ahead_row
                  || s1_edge_reg.zlo || !v_older
                  || s1_edge_reg.zhi || !s1_cur_reg;
        surf       = v_center && empty_face;
        count_next = count_reg + TOTAL_W'(surf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= '0;
        end
        else if (s1_adv && s1_produce_reg)
        begin
            count_reg <= s1_final_reg ? '0 : count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_produce_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_produce_reg)
        begin
            out_surface_reg <= surf;
            out_x_reg       <= POS_W'(s1_x_reg);
            out_y_reg       <= POS_W'(s1_y_reg);
            out_z_reg       <= POS_W'(s1_z_reg);
            out_total_reg   <= count_next;
            out_final_reg   <= s1_final_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.surface       = out_surface_reg;
    assign results.pos_x         = out_x_reg;
    assign results.pos_y         = out_y_reg;
    assign results.pos_z         = out_z_reg;
    assign results.surface_total = out_total_reg;
    assign results.final_voxel   = out_final_reg;

    `VSE_ASSERT_ALWAYS(a_addr_in_plane, SUMW'(addr_reg) < SUMW'(plane_reg), "window address past plane")
    `VSE_ASSERT_ALWAYS(a_coord_range, (GW'(x_in_reg) < side_reg) && (GW'(y_in_reg) < side_reg) && (z_in_reg <= side_reg), "scan coordinate out of range")
    `VSE_ASSERT_NEXT(a_grid_restart, !cfg_we && s1_adv && s1_produce_reg && s1_final_reg, (count_reg == '0) && (z_in_reg == '0 || in_take), "grid end did not restart the scan")

endmodule

@@ rtl/vse_window_ram.sv @@
// Plane window RAM: one write port, two registered read ports.
// Depends on vse_pkg for the entry layout.
module vse_window_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr_a,
    input  logic [AW-1:0]                rd_addr_b,
    output logic [vse_pkg::ENTRY_W-1:0]  rd_data_a,
    output logic                         rd_recent_b,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [vse_pkg::ENTRY_W-1:0]  wr_data
);

    logic [vse_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [vse_pkg::ENTRY_W-1:0] rd_a_reg;
    logic                        rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b][vse_pkg::BIT_RECENT];
        end
    end

    assign rd_data_a   = rd_a_reg;
    assign rd_recent_b = rd_b_reg;

endmodule

@@ rtl/vse_line_delay.sv @@
// Bit delay line with a run-time length: insert at the tap, shift toward bit 0.
// No dependencies.
module vse_line_delay #(
    parameter int DEPTH = 64,
    parameter int TW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          shift_en,
    input  logic [TW-1:0] tap,
    input  logic          din,
    output logic          dout
);

    logic [DEPTH-1:0] line_reg;
    logic [DEPTH-1:0] line_next;

    always_comb
    begin
        line_next      = {1'b0, line_reg[DEPTH-1:1]};
        line_next[tap] = din;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            line_reg <= line_next;
        end
    end

    assign dout = line_reg[0];

endmodule

@@ bench/voxel_surface_extract_6n_core_tb.sv @@
// Self-checking bench for voxel_surface_extract_6n_core: streams voxel items, predicts each
// surface report as items are taken and compares every report field as results arrive.
// Depends on vse_pkg, the vse_in_if/vse_out_if channels and the core RTL.
module voxel_surface_extract_6n_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W         = vse_pkg::CFG_W;
    localparam int POS_W         = vse_pkg::POS_W;
    localparam int TOTAL_W       = vse_pkg::TOTAL_W;
    localparam int MIN_SIDE      = vse_pkg::MIN_SIDE;
    localparam int RESET_SIDE    = vse_pkg::RESET_SIDE;
    localparam int SIDE_MAX      = vse_pkg::MAX_SIDE_DEFAULT;
    localparam int WINDOW_BITS   = 2 * SIDE_MAX * SIDE_MAX;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 880;

    typedef struct packed {
        logic               surface;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [TOTAL_W-1:0] surface_total;
        logic               final_voxel;
    } voxel_report_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    vse_in_if  voxels_ch ();
    vse_out_if results_ch ();

    voxel_surface_extract_6n_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .voxels   (voxels_ch),
        .results  (results_ch)
    );

    bit            window_mem [WINDOW_BITS];
    int unsigned   grid_side;
    int unsigned   voxel_count;
    int unsigned   report_index;
    int unsigned   surface_count;
    voxel_report_t pending_reports [$];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatches;
    int taken_items;
    int reports_checked;
    int grids_done;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned clamp_side(input int unsigned value);
        if (value < MIN_SIDE)
            return MIN_SIDE;
        if (value > SIDE_MAX)
            return SIDE_MAX;
        return value;
    endfunction

    function automatic bit window_at(input int unsigned idx);
        return window_mem[idx % (2 * grid_side * grid_side)];
    endfunction

    // Returns 1 when the item is taken into the stream, 0 when it is ignored.
    function automatic bit classify_voxel(input bit occ, input bit pd);
        int unsigned   plane;
        int unsigned   last;
        int unsigned   c;
        int unsigned   x;
        int unsigned   y;
        int unsigned   z;
        bit            cur;
        bit            exposed;
        voxel_report_t rep;
        plane = grid_side * grid_side;
        last  = plane * grid_side - 1;
        cur   = 1'b0;
        if (voxel_count <= last)
        begin
            if (pd)
                return 1'b0;
            cur = occ;
        end
        if (voxel_count >= plane)
        begin
            c = report_index;
            x = c % grid_side;
            y = (c / grid_side) % grid_side;
            z = c / plane;
            exposed = window_at(c) && (x == 0 || !window_at(c - 1)
                || x == grid_side - 1 || !window_at(c + 1)
                || y == 0 || !window_at(c - grid_side)
                || y == grid_side - 1 || !window_at(c + grid_side)
                || z == 0 || !window_at(c - plane)
                || z == grid_side - 1 || !cur);
            if (exposed)
                surface_count = (surface_count + 1) & ((1 << TOTAL_W) - 1);
            rep.surface       = exposed;
            rep.pos_x         = x[POS_W-1:0];
            rep.pos_y         = y[POS_W-1:0];
            rep.pos_z         = z[POS_W-1:0];
            rep.surface_total = surface_count[TOTAL_W-1:0];
            rep.final_voxel   = (c == last);
            pending_reports.push_back(rep);
        end
        window_mem[voxel_count % (2 * plane)] = cur;
        if (voxel_count >= plane && report_index == last)
        begin
            voxel_count   = 0;
            report_index  = 0;
            surface_count = 0;
            grids_done++;
        end
        else
        begin
            if (voxel_count >= plane)
                report_index++;
            voxel_count++;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_report();
        voxel_report_t want;
        if (pending_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: report expected none, actual (%0d,%0d,%0d) surface %0d",
                     $time, results_ch.pos_x, results_ch.pos_y, results_ch.pos_z,
                     results_ch.surface);
            return;
        end
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("surface", TOTAL_W'(want.surface), TOTAL_W'(results_ch.surface));
        check_field("pos_x", TOTAL_W'(want.pos_x), TOTAL_W'(results_ch.pos_x));
        check_field("pos_y", TOTAL_W'(want.pos_y), TOTAL_W'(results_ch.pos_y));
        check_field("pos_z", TOTAL_W'(want.pos_z), TOTAL_W'(results_ch.pos_z));
        check_field("surface_total", want.surface_total, results_ch.surface_total);
        check_field("final_voxel", TOTAL_W'(want.final_voxel),
                    TOTAL_W'(results_ch.final_voxel));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
                check_report();
            results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || cfg_we === 1'b1
            || (voxels_ch.valid === 1'b1 && voxels_ch.ready === 1'b1)
            || (results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("voxel_surface_extract_6n_core_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_voxel(input bit occ, input bit pd);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            voxels_ch.valid <= 1'b0;
            @(posedge clk);
        end
        voxels_ch.valid    <= 1'b1;
        voxels_ch.occupied <= occ;
        voxels_ch.pad      <= pd;
        do
            @(posedge clk);
        while (!(voxels_ch.valid === 1'b1 && voxels_ch.ready === 1'b1));
        if (classify_voxel(occ, pd))
            taken_items++;
    endtask

    task automatic send_random_voxels(input int count, input int density);
        repeat (count)
            send_voxel($urandom_range(99) < density, 1'b0);
    endtask

    task automatic hold_until_drained();
        voxels_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        grid_side     = clamp_side(32'(value));
        voxel_count   = 0;
        report_index  = 0;
        surface_count = 0;
        @(posedge clk);
    endtask

    task automatic test_reset_side();
        send_random_voxels(2 * SIDE_MAX, 85);
        settle();
    endtask

    task automatic test_tiny_grid();
        write_side(7'd2);
        send_voxel(1'b1, 1'b1);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b0, 1'b0);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b0, 1'b1);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b0, 1'b0);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b1, 1'b1);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b1, 1'b1);
        send_voxel(1'b0, 1'b0);
        send_voxel(1'b1, 1'b0);
        send_voxel(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_solid_interior();
        write_side(7'd3);
        repeat (27)
            send_voxel(1'b1, 1'b0);
        repeat (9)
            send_voxel(1'b1, 1'b1);
        settle();
    endtask

    task automatic test_side_clamp();
        write_side(7'd0);
        send_random_voxels(12, 70);
        settle();
        write_side(7'd1);
        send_random_voxels(12, 100);
        settle();
        write_side(7'h7f);
        send_random_voxels(SIDE_MAX + 4, 80);
        settle();
    endtask

    task automatic test_restart();
        write_side(7'd4);
        send_random_voxels(30, 80);
        settle();
        write_side(7'd4);
        send_random_voxels(80, 80);
        settle();
        write_side(7'd5);
        send_random_voxels(32, 90);
        settle();
        write_side(7'd3);
        send_random_voxels(72, 90);
        settle();
    endtask

    task automatic test_pressure();
        write_side(7'd4);
        send_random_voxels(36, 90);
        hold_until_drained();
        send_random_voxels(28, 90);
        repeat (16)
            send_voxel(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_random(input int target);
        int goal;
        int unsigned side_val;
        int unsigned density;
        int unsigned plane;
        int unsigned total;
        int unsigned cut;
        int unsigned sent;
        goal = taken_items + target;
        while (taken_items < goal)
        begin
            side_val = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 0);
            if (clamp_side(side_val) != grid_side || voxel_count != 0
                || $urandom_range(7) == 0)
            begin
                settle();
                write_side(side_val[CFG_W-1:0]);
            end
            case ($urandom_range(4))
                0: density = 0;
                1: density = 40;
                2: density = 75;
                3: density = 93;
                default: density = 100;
            endcase
            plane = grid_side * grid_side;
            total = plane * grid_side;
            cut = ($urandom_range(9) == 0) ? $urandom_range(total + plane - 1, 1)
                                           : total + plane;
            for (sent = 0; sent < cut && taken_items < goal; sent++)
            begin
                if (sent < total && $urandom_range(24) == 0)
                    send_voxel(1'($urandom_range(1)), 1'b1);
                if (sent < total)
                    send_voxel($urandom_range(99) < density, 1'b0);
                else
                    send_voxel(1'($urandom_range(1)), 1'($urandom_range(1)));
                if (sent == total / 2 && $urandom_range(19) == 0)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        voxels_ch.valid    <= 1'b0;
        voxels_ch.occupied <= 1'b0;
        voxels_ch.pad      <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        rst_n              <= 1'b0;
        grid_side     = RESET_SIDE;
        voxel_count   = 0;
        report_index  = 0;
        surface_count = 0;
        send_gap_pct   = 11;
        recv_stall_pct = 50;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_side();
        test_tiny_grid();
        test_solid_interior();
        test_side_clamp();
        test_restart();
        test_pressure();
        test_random(RANDOM_ITEMS / 3);

        send_gap_pct   = 50;
        recv_stall_pct = 11;
        test_random(RANDOM_ITEMS / 3);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        settle();

        $display("run took %0d voxel items and checked %0d surface reports, %0d full grids",
                 taken_items, reports_checked, grids_done);
        $display("sides 2 to 64 with clamped writes, restarts, early pads and late voxels");
        if (mismatches == 0)
            $display("voxel_surface_extract_6n_core_tb: PASS");
        else
            $display("voxel_surface_extract_6n_core_tb: FAIL");
        $finish;
    end

endmodule
